### hdl/imhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;

   localparam int HEAP_CAPACITY_DEF = 256;
   localparam int KEY_BITS_DEF      = 32;
   localparam int ID_BITS           = 8;
   localparam int ID_COUNT          = 1 << ID_BITS;
   localparam int IN_KEY_BITS       = 32;
   localparam int ENTRY_BITS        = 9;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK,
      S_UPD_OLD,
      S_READ,
      S_RM_TOP,
      S_RM_LAST,
      S_UP,
      S_UP_CMP,
      S_DOWN,
      S_DN_L,
      S_DN_R,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

### hdl/indexed_min_heap_queue.sv
// One request at a time, paced by the single heap memory read port. A read-key or a rejected
// request goes straight to the response; an insert or key lowering sifts the item up, a
// remove-min or key raise sifts it down. The response turns valid as the sequencer returns to
// idle and req_tready rises again; a response not yet taken holds the sequencer in its done
// state. Reset clears the sequencer, the item count, the id-present bits and the response
// valid flag; the heap and id-to-slot memories need no sweep.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue #(
   parameter int HEAP_CAPACITY = imhq_pkg::HEAP_CAPACITY_DEF,
   parameter int KEY_BITS      = imhq_pkg::KEY_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // item_id[7:0], new_key[39:8]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // out_id[7:0], out_key[39:8], entries[48:40], zero
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int SW = $clog2(HEAP_CAPACITY + 1);
   localparam int AW = $clog2(HEAP_CAPACITY);
   localparam int IB = imhq_pkg::ID_BITS;
   localparam int KB = imhq_pkg::IN_KEY_BITS;
   localparam int EB = imhq_pkg::ENTRY_BITS;

   // memories
   logic [IB-1:0]       heap_id_mem  [HEAP_CAPACITY];
   logic [KEY_BITS-1:0] heap_key_mem [HEAP_CAPACITY];
   logic [SW-1:0]       map_mem      [imhq_pkg::ID_COUNT];
   logic [IB-1:0]       heap_q_id;
   logic [KEY_BITS-1:0] heap_q_key;
   logic [SW-1:0]       map_q;
   logic                heap_re;
   logic [AW-1:0]       heap_raddr;
   logic                wr_en;
   logic [IB-1:0]       wr_id;
   logic [KEY_BITS-1:0] wr_key;
   logic [SW-1:0]       wr_slot;
   logic                vld_clr;
   logic [IB-1:0]       vld_clr_id;
   logic [imhq_pkg::ID_COUNT-1:0] pos_vld_ff;

   imhq_pkg::state_type  state_ff, state_in;
   imhq_pkg::mode_type   mode_ff, mode_in;
   logic [IB-1:0]        id_ff, id_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [IB-1:0]        elem_id_ff, elem_id_in;
   logic [KEY_BITS-1:0]  elem_key_ff, elem_key_in;
   logic [IB-1:0]        left_id_ff, left_id_in;
   logic [KEY_BITS-1:0]  left_key_ff, left_key_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic [IB-1:0]        res_id_ff, res_id_in;
   logic [KB-1:0]        res_key_ff, res_key_in;
   imhq_pkg::status_type res_st_ff, res_st_in;
   logic                 rsp_valid_ff;
   logic [IB-1:0]        rsp_id_ff;
   logic [KB-1:0]        rsp_key_ff;
   imhq_pkg::status_type rsp_st_ff;
   logic [EB-1:0]        rsp_ent_ff;
   logic                 rsp_load;

   logic [SW-1:0]        s_look;
   logic [SW:0]          lft;
   logic [SW:0]          rgt;
   logic [SW:0]          cnt_ext;
   logic [IB-1:0]        ch_id;
   logic [KEY_BITS-1:0]  ch_key;
   logic [SW:0]          ch_slot;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_id_mem[AW'(wr_slot - 1'b1)]  <= wr_id;
         heap_key_mem[AW'(wr_slot - 1'b1)] <= wr_key;
         map_mem[wr_id]                    <= wr_slot;
      end
      if (heap_re) begin
         heap_q_id  <= heap_id_mem[heap_raddr];
         heap_q_key <= heap_key_mem[heap_raddr];
      end
      map_q <= map_mem[req_tdata[IB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= '0;
      end else begin
         if (vld_clr) begin
            pos_vld_ff[vld_clr_id] <= 1'b0;
         end
         if (wr_en) begin
            pos_vld_ff[wr_id] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imhq_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mode_ff     <= mode_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      elem_id_ff  <= elem_id_in;
      elem_key_ff <= elem_key_in;
      left_id_ff  <= left_id_in;
      left_key_ff <= left_key_in;
      slot_ff     <= slot_in;
      res_id_ff   <= res_id_in;
      res_key_ff  <= res_key_in;
      res_st_ff   <= res_st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_id_ff  <= res_id_ff;
         rsp_key_ff <= res_key_ff;
         rsp_st_ff  <= res_st_ff;
         rsp_ent_ff <= EB'(cnt_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ent_ff, rsp_key_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_st_ff;
   assign req_tready = (state_ff == imhq_pkg::S_IDLE);

   assign s_look  = pos_vld_ff[id_ff] ? map_q : '0;
   assign lft     = {slot_ff, 1'b0};
   assign rgt     = {slot_ff, 1'b1};
   assign cnt_ext = {1'b0, cnt_ff};

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      elem_id_in  = elem_id_ff;
      elem_key_in = elem_key_ff;
      left_id_in  = left_id_ff;
      left_key_in = left_key_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      res_id_in   = res_id_ff;
      res_key_in  = res_key_ff;
      res_st_in   = res_st_ff;
      heap_re     = 1'b0;
      heap_raddr  = '0;
      wr_en       = 1'b0;
      wr_id       = elem_id_ff;
      wr_key      = elem_key_ff;
      wr_slot     = slot_ff;
      vld_clr     = 1'b0;
      vld_clr_id  = heap_q_id;
      rsp_load    = 1'b0;
      ch_id       = heap_q_id;
      ch_key      = heap_q_key;
      ch_slot     = lft;

      case (state_ff)
         imhq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = imhq_pkg::mode_type'(req_tuser);
               id_in    = req_tdata[IB-1:0];
               key_in   = KEY_BITS'(req_tdata[IB +: KB]);
               state_in = imhq_pkg::S_LOOK;
            end
         end
         imhq_pkg::S_LOOK: begin
            res_id_in  = id_ff;
            res_key_in = '0;
            res_st_in  = imhq_pkg::ST_OK;
            case (mode_ff)
               imhq_pkg::MODE_INSERT, imhq_pkg::MODE_UPDATE: begin
                  if (s_look != '0) begin
                     slot_in    = s_look;
                     heap_re    = 1'b1;
                     heap_raddr = AW'(s_look - 1'b1);
                     state_in   = imhq_pkg::S_UPD_OLD;
                  end else if (mode_ff == imhq_pkg::MODE_UPDATE) begin
                     res_st_in = imhq_pkg::ST_ABSENT;
                     state_in  = imhq_pkg::S_DONE;
                  end else if (cnt_ff == SW'(HEAP_CAPACITY)) begin
                     res_st_in = imhq_pkg::ST_FULL;
                     state_in  = imhq_pkg::S_DONE;
                  end else begin
                     cnt_in      = cnt_ff + 1'b1;
                     slot_in     = cnt_ff + 1'b1;
                     elem_id_in  = id_ff;
                     elem_key_in = key_ff;
                     res_key_in  = KB'(key_ff);
                     state_in    = imhq_pkg::S_UP;
                  end
               end
               imhq_pkg::MODE_REMOVE: begin
                  if (cnt_ff == '0) begin
                     res_id_in = '0;
                     res_st_in = imhq_pkg::ST_EMPTY;
                     state_in  = imhq_pkg::S_DONE;
                  end else begin
                     heap_re    = 1'b1;
                     heap_raddr = '0;
                     state_in   = imhq_pkg::S_RM_TOP;
                  end
               end
               default: begin
                  if (s_look == '0) begin
                     res_st_in = imhq_pkg::ST_ABSENT;
                     state_in  = imhq_pkg::S_DONE;
                  end else begin
                     heap_re    = 1'b1;
                     heap_raddr = AW'(s_look - 1'b1);
                     state_in   = imhq_pkg::S_READ;
                  end
               end
            endcase
         end
         imhq_pkg::S_UPD_OLD: begin
            res_key_in  = KB'(key_ff);
            elem_id_in  = id_ff;
            elem_key_in = key_ff;
            if (key_ff < heap_q_key) begin
               state_in = imhq_pkg::S_UP;
            end else if (key_ff > heap_q_key) begin
               state_in = imhq_pkg::S_DOWN;
            end else begin
               wr_en    = 1'b1;
               wr_id    = id_ff;
               wr_key   = key_ff;
               state_in = imhq_pkg::S_DONE;
            end
         end
         imhq_pkg::S_READ: begin
            res_key_in = KB'(heap_q_key);
            state_in   = imhq_pkg::S_DONE;
         end
         imhq_pkg::S_RM_TOP: begin
            res_id_in  = heap_q_id;
            res_key_in = KB'(heap_q_key);
            vld_clr    = 1'b1;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == SW'(1)) begin
               state_in = imhq_pkg::S_DONE;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = AW'(cnt_ff - 1'b1);
               state_in   = imhq_pkg::S_RM_LAST;
            end
         end
         imhq_pkg::S_RM_LAST: begin
            elem_id_in  = heap_q_id;
            elem_key_in = heap_q_key;
            slot_in     = SW'(1);
            state_in    = imhq_pkg::S_DOWN;
         end
         imhq_pkg::S_UP: begin
            if (slot_ff == SW'(1)) begin
               wr_en    = 1'b1;
               state_in = imhq_pkg::S_DONE;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = AW'((slot_ff >> 1) - 1'b1);
               state_in   = imhq_pkg::S_UP_CMP;
            end
         end
         imhq_pkg::S_UP_CMP: begin
            wr_en = 1'b1;
            if (heap_q_key > elem_key_ff) begin
               // move parent down into the hole
               wr_id    = heap_q_id;
               wr_key   = heap_q_key;
               slot_in  = slot_ff >> 1;
               state_in = imhq_pkg::S_UP;
            end else begin
               state_in = imhq_pkg::S_DONE;
            end
         end
         imhq_pkg::S_DOWN: begin
            if (lft > cnt_ext) begin
               wr_en    = 1'b1;
               state_in = imhq_pkg::S_DONE;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = AW'(lft - 1'b1);
               state_in   = imhq_pkg::S_DN_L;
            end
         end
         imhq_pkg::S_DN_L, imhq_pkg::S_DN_R: begin
            if (state_ff == imhq_pkg::S_DN_L) begin
               left_id_in  = heap_q_id;
               left_key_in = heap_q_key;
            end else if (left_key_ff < heap_q_key) begin
               ch_id  = left_id_ff;
               ch_key = left_key_ff;
            end else begin
               ch_slot = rgt;
            end
            if (state_ff == imhq_pkg::S_DN_L && rgt <= cnt_ext) begin
               heap_re    = 1'b1;
               heap_raddr = AW'(rgt - 1'b1);
               state_in   = imhq_pkg::S_DN_R;
            end else if (elem_key_ff <= ch_key) begin
               wr_en    = 1'b1;
               state_in = imhq_pkg::S_DONE;
            end else begin
               // move the smaller child up into the hole
               wr_en    = 1'b1;
               wr_id    = ch_id;
               wr_key   = ch_key;
               slot_in  = SW'(ch_slot);
               state_in = imhq_pkg::S_DOWN;
            end
         end
         imhq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = imhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = imhq_pkg::S_IDLE;
         end
      endcase
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SW'(HEAP_CAPACITY))
      else $error("item count above capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + 1'b1 ||
                         cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("item count jumped");

   a_sift_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imhq_pkg::S_UP || state_ff == imhq_pkg::S_DOWN) |->
         (slot_ff != '0 && slot_ff <= cnt_ff))
      else $error("sift slot outside heap");

   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_st_ff == imhq_pkg::ST_EMPTY) |-> cnt_ff == '0)
      else $error("empty status with items present");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_slot != '0 && wr_slot <= cnt_ff))
      else $error("heap write outside occupied slots");

endmodule
`default_nettype wire
